// ===== hdl/tfu_pkg.sv =====
// shared types and constants of the triangle tangent frame unit
// no dependencies
`default_nettype none

package tfu_pkg;

   localparam int UV_WIDTH   = 16;
   localparam int OUT_WIDTH  = 16;
   localparam int DUV_WIDTH  = UV_WIDTH + 1;
   localparam int SCALE_BIT  = 23;
   localparam int SCALED_W   = SCALE_BIT + 1;
   localparam int SUMSQ_W    = 2 * SCALED_W + 2;
   localparam int ROOT_W     = SUMSQ_W + 1;
   localparam int QUOT_W     = 17;
   localparam int FRAC_SHIFT = 15;
   localparam logic [QUOT_W-1:0] UNIT_Q14 = QUOT_W'(16384);

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

// ===== hdl/triangle_tangent_frame_unit.sv =====
// top level of the triangle tangent frame unit
// depends on tfu_pkg, tfu_front, tfu_queue and tfu_back
`default_nettype none

// Vertices come in one request per cycle, three to a triangle; the third vertex of
// each triangle produces one unit tangent and unit binormal in Q1.14 plus a
// degenerate flag. The front end takes a vertex every cycle while the two-entry
// queue has room. Each triangle then passes through the single frame engine: it
// is taken from the queue, its products are formed on one shared multiplier, and
// each non-zero vector is loaded, scaled one bit at a time (up to 23 bits, or
// COORD_WIDTH-6 where that is larger) until it settles, then goes through the sum
// of squares, the square root, three divisions and a step to move on; a zero
// vector goes from the load straight to that last step. The result register is
// then loaded once the previous result has been taken. That engine sets the
// sustained rate.

module triangle_tangent_frame_unit #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [COORD_WIDTH-1:0]       req_pos_x,
   input  wire logic signed [COORD_WIDTH-1:0]       req_pos_y,
   input  wire logic signed [COORD_WIDTH-1:0]       req_pos_z,
   input  wire logic signed [tfu_pkg::UV_WIDTH-1:0] req_tex_u,
   input  wire logic signed [tfu_pkg::UV_WIDTH-1:0] req_tex_v,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [tfu_pkg::OUT_WIDTH-1:0]     rsp_tangent_x,
   output logic signed [tfu_pkg::OUT_WIDTH-1:0]     rsp_tangent_y,
   output logic signed [tfu_pkg::OUT_WIDTH-1:0]     rsp_tangent_z,
   output logic signed [tfu_pkg::OUT_WIDTH-1:0]     rsp_binormal_x,
   output logic signed [tfu_pkg::OUT_WIDTH-1:0]     rsp_binormal_y,
   output logic signed [tfu_pkg::OUT_WIDTH-1:0]     rsp_binormal_z,
   output logic                                     rsp_degenerate
);

   localparam int JW = 6 * (COORD_WIDTH + 1) + 4 * tfu_pkg::DUV_WIDTH;

   tfu_pkg::q_status_type q_status;
   logic                  push, pop;
   logic [JW-1:0]         push_data, pop_data;

   tfu_front #(.CW(COORD_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_pos_x (req_pos_x),
      .req_pos_y (req_pos_y),
      .req_pos_z (req_pos_z),
      .req_tex_u (req_tex_u),
      .req_tex_v (req_tex_v),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   tfu_queue #(.WIDTH(JW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   tfu_back #(.CW(COORD_WIDTH)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .pop_data       (pop_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_tangent_x  (rsp_tangent_x),
      .rsp_tangent_y  (rsp_tangent_y),
      .rsp_tangent_z  (rsp_tangent_z),
      .rsp_binormal_x (rsp_binormal_x),
      .rsp_binormal_y (rsp_binormal_y),
      .rsp_binormal_z (rsp_binormal_z),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule

`default_nettype wire

// ===== hdl/tfu_queue.sv =====
// two-entry queue between vertex front end and frame engine
// depends on tfu_pkg
`default_nettype none

module tfu_queue #(
   parameter int WIDTH = 170
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output tfu_pkg::q_status_type status
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tfu_front.sv =====
// vertex front end: holds two vertices and forms triangle edges and uv deltas
// depends on tfu_pkg
`default_nettype none

module tfu_front #(
   parameter int CW = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [CW-1:0]              req_pos_x,
   input  wire logic signed [CW-1:0]              req_pos_y,
   input  wire logic signed [CW-1:0]              req_pos_z,
   input  wire logic signed [tfu_pkg::UV_WIDTH-1:0] req_tex_u,
   input  wire logic signed [tfu_pkg::UV_WIDTH-1:0] req_tex_v,
   input  tfu_pkg::q_status_type                  q_status,
   output logic                                   push,
   output logic [6*(CW+1)+4*tfu_pkg::DUV_WIDTH-1:0] push_data
);

   localparam int SW = CW + 1;
   localparam int DW = tfu_pkg::DUV_WIDTH;

   logic signed [CW-1:0] held_pos_ff [2][3];
   logic signed [tfu_pkg::UV_WIDTH-1:0] held_u_ff [2];
   logic signed [tfu_pkg::UV_WIDTH-1:0] held_v_ff [2];
   logic [1:0] slot_ff;
   logic       accept;
   logic signed [SW-1:0] s0 [3];
   logic signed [SW-1:0] s1 [3];
   logic signed [CW-1:0] cur [3];
   logic signed [DW-1:0] du0, du1, dv0, dv1;

   assign req_ready = (slot_ff != 2'd2) || !q_status.full;
   assign accept    = req_valid && req_ready;
   assign push      = accept && (slot_ff == 2'd2);

   assign cur[0] = req_pos_x;
   assign cur[1] = req_pos_y;
   assign cur[2] = req_pos_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s0[i] = SW'(held_pos_ff[0][i]) - SW'(held_pos_ff[1][i]);
         s1[i] = SW'(cur[i]) - SW'(held_pos_ff[0][i]);
      end
      du0 = DW'(held_u_ff[0]) - DW'(held_u_ff[1]);
      du1 = DW'(req_tex_u) - DW'(held_u_ff[0]);
      dv0 = DW'(held_v_ff[0]) - DW'(held_v_ff[1]);
      dv1 = DW'(req_tex_v) - DW'(held_v_ff[0]);
   end

   assign push_data = {s0[0], s0[1], s0[2], s1[0], s1[1], s1[2], du0, du1, dv0, dv1};

   always_ff @(posedge clock) begin
      if (accept && (slot_ff != 2'd2)) begin
         held_pos_ff[slot_ff[0]][0] <= req_pos_x;
         held_pos_ff[slot_ff[0]][1] <= req_pos_y;
         held_pos_ff[slot_ff[0]][2] <= req_pos_z;
         held_u_ff[slot_ff[0]]      <= req_tex_u;
         held_v_ff[slot_ff[0]]      <= req_tex_v;
      end
      if (reset) begin
         slot_ff <= 2'd0;
      end else if (accept) begin
         slot_ff <= (slot_ff == 2'd2) ? 2'd0 : slot_ff + 2'd1;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tfu_back.sv =====
// frame engine: products, normalisation, tangent flip and result register
// depends on tfu_pkg
`default_nettype none

module tfu_back #(
   parameter int CW = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  tfu_pkg::q_status_type                    q_status,
   input  wire logic [6*(CW+1)+4*tfu_pkg::DUV_WIDTH-1:0] pop_data,
   output logic                                     pop,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [tfu_pkg::OUT_WIDTH-1:0]     rsp_tangent_x,
   output logic signed [tfu_pkg::OUT_WIDTH-1:0]     rsp_tangent_y,
   output logic signed [tfu_pkg::OUT_WIDTH-1:0]     rsp_tangent_z,
   output logic signed [tfu_pkg::OUT_WIDTH-1:0]     rsp_binormal_x,
   output logic signed [tfu_pkg::OUT_WIDTH-1:0]     rsp_binormal_y,
   output logic signed [tfu_pkg::OUT_WIDTH-1:0]     rsp_binormal_z,
   output logic                                     rsp_degenerate
);

   localparam int SW  = CW + 1;
   localparam int DW  = tfu_pkg::DUV_WIDTH;
   localparam int PW  = (SW > DW) ? SW : DW;
   localparam int RW  = 2 * PW + 1;
   localparam int VW  = CW + 19;
   localparam int MW  = CW + 18;
   localparam int NW  = tfu_pkg::SCALED_W;
   localparam int SQW = 2 * NW;
   localparam int XW  = tfu_pkg::ROOT_W;
   localparam int LW  = NW + 2;
   localparam int QW  = tfu_pkg::QUOT_W;
   localparam int OW  = tfu_pkg::OUT_WIDTH;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_LOAD, ST_SHIFT, ST_SQ, ST_SQRT,
      ST_DINIT, ST_DIV, ST_DFIN, ST_NEXT, ST_FINISH
   } state_type;

   state_type state_ff;

   logic signed [SW-1:0] s0_ff [3];
   logic signed [SW-1:0] s1_ff [3];
   logic signed [DW-1:0] du0_ff, du1_ff, dv0_ff, dv1_ff;
   logic [4:0]           k_ff;
   logic signed [PW-1:0] op_a, op_b;
   logic signed [2*PW-1:0] prod_ff, acc_ff;
   logic signed [RW-1:0] mul_diff;
   logic [3:0]           pair;
   logic signed [VW-1:0] tb_ff [2][3];
   logic                 nn_ff, det_pos_ff;
   logic                 vec_ff;
   logic                 zero_ff [2];
   logic [MW-1:0]        mag_ff [3];
   logic                 sgn_ff [3];
   logic [SQW-1:0]       sq_ff;
   logic [XW-1:0]        ssum_ff, sx_ff, rt_ff, bit_ff;
   logic [NW-1:0]        sq_src;
   logic [1:0]           i_ff;
   logic [LW-1:0]        rem_ff;
   logic [QW-1:0]        num_ff, q_ff;
   logic [LW:0]          div_t;
   logic [LW-1:0]        len;
   logic [QW-1:0]        rnd;
   logic signed [OW-1:0] res_ff [2][3];
   logic                 shift_hi, shift_lo;
   logic signed [VW-1:0] ld_v [3];
   logic                 flip;

   logic                 rsp_valid_ff;
   logic signed [OW-1:0] out_ff [6];
   logic                 deg_ff;

   assign pop            = (state_ff == ST_IDLE) && !q_status.empty;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tangent_x  = out_ff[0];
   assign rsp_tangent_y  = out_ff[1];
   assign rsp_tangent_z  = out_ff[2];
   assign rsp_binormal_x = out_ff[3];
   assign rsp_binormal_y = out_ff[4];
   assign rsp_binormal_z = out_ff[5];
   assign rsp_degenerate = deg_ff;

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (k_ff)
         5'd0:  begin op_a = PW'(s0_ff[0]); op_b = PW'(dv1_ff); end
         5'd1:  begin op_a = PW'(s1_ff[0]); op_b = PW'(dv0_ff); end
         5'd2:  begin op_a = PW'(s0_ff[1]); op_b = PW'(dv1_ff); end
         5'd3:  begin op_a = PW'(s1_ff[1]); op_b = PW'(dv0_ff); end
         5'd4:  begin op_a = PW'(s0_ff[2]); op_b = PW'(dv1_ff); end
         5'd5:  begin op_a = PW'(s1_ff[2]); op_b = PW'(dv0_ff); end
         5'd6:  begin op_a = PW'(s0_ff[0]); op_b = PW'(du1_ff); end
         5'd7:  begin op_a = PW'(s1_ff[0]); op_b = PW'(du0_ff); end
         5'd8:  begin op_a = PW'(s0_ff[1]); op_b = PW'(du1_ff); end
         5'd9:  begin op_a = PW'(s1_ff[1]); op_b = PW'(du0_ff); end
         5'd10: begin op_a = PW'(s0_ff[2]); op_b = PW'(du1_ff); end
         5'd11: begin op_a = PW'(s1_ff[2]); op_b = PW'(du0_ff); end
         5'd12: begin op_a = PW'(s0_ff[1]); op_b = PW'(s1_ff[2]); end
         5'd13: begin op_a = PW'(s0_ff[2]); op_b = PW'(s1_ff[1]); end
         5'd14: begin op_a = PW'(s0_ff[2]); op_b = PW'(s1_ff[0]); end
         5'd15: begin op_a = PW'(s0_ff[0]); op_b = PW'(s1_ff[2]); end
         5'd16: begin op_a = PW'(s0_ff[0]); op_b = PW'(s1_ff[1]); end
         5'd17: begin op_a = PW'(s0_ff[1]); op_b = PW'(s1_ff[0]); end
         5'd18: begin op_a = PW'(dv0_ff);   op_b = PW'(du1_ff); end
         5'd19: begin op_a = PW'(dv1_ff);   op_b = PW'(du0_ff); end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   assign mul_diff = RW'(acc_ff) - RW'(prod_ff);
   assign pair     = 4'((k_ff - 5'd1) >> 1);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ld_v[i] = tb_ff[vec_ff][i];
      end
      shift_hi = 1'b0;
      shift_lo = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (mag_ff[i][MW-1:NW] != '0) begin
            shift_hi = 1'b1;
         end
         if (mag_ff[i][MW-1:tfu_pkg::SCALE_BIT] != '0) begin
            shift_lo = 1'b0;
         end
      end
      case (k_ff[1:0])
         2'd0:    sq_src = mag_ff[0][NW-1:0];
         2'd1:    sq_src = mag_ff[1][NW-1:0];
         default: sq_src = mag_ff[2][NW-1:0];
      endcase
      len   = rt_ff[LW-1:0];
      div_t = {1'b0, rem_ff[LW-2:0], num_ff[QW-1]};
      rnd   = (q_ff + QW'(1)) >> 1;
      if (rnd > tfu_pkg::UNIT_Q14) begin
         rnd = tfu_pkg::UNIT_Q14;
      end
      flip = !zero_ff[0] && !zero_ff[1] && nn_ff && det_pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         vec_ff       <= 1'b0;
         i_ff         <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_status.empty) begin
                  {s0_ff[0], s0_ff[1], s0_ff[2], s1_ff[0], s1_ff[1], s1_ff[2],
                   du0_ff, du1_ff, dv0_ff, dv1_ff} <= pop_data;
                  k_ff       <= '0;
                  nn_ff      <= 1'b0;
                  det_pos_ff <= 1'b0;
                  state_ff   <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff <= op_a * op_b;
               if (k_ff != 5'd0) begin
                  if (!k_ff[0]) begin
                     if (pair < 4'd3) begin
                        tb_ff[0][pair[1:0]] <= VW'(mul_diff);
                     end else if (pair < 4'd6) begin
                        tb_ff[1][2'(pair - 4'd3)] <= VW'(mul_diff);
                     end else if (pair < 4'd9) begin
                        nn_ff <= nn_ff || (mul_diff != '0);
                     end else begin
                        det_pos_ff <= (mul_diff > 0);
                     end
                  end else begin
                     acc_ff <= prod_ff;
                  end
               end
               if (k_ff == 5'd20) begin
                  vec_ff   <= 1'b0;
                  state_ff <= ST_LOAD;
               end else begin
                  k_ff <= k_ff + 5'd1;
               end
            end
            ST_LOAD: begin
               for (int i = 0; i < 3; i++) begin
                  sgn_ff[i] <= ld_v[i][VW-1];
                  mag_ff[i] <= MW'(ld_v[i][VW-1] ? -ld_v[i] : ld_v[i]);
               end
               if (ld_v[0] == '0 && ld_v[1] == '0 && ld_v[2] == '0) begin
                  zero_ff[vec_ff] <= 1'b1;
                  for (int i = 0; i < 3; i++) begin
                     res_ff[vec_ff][i] <= '0;
                  end
                  state_ff <= ST_NEXT;
               end else begin
                  zero_ff[vec_ff] <= 1'b0;
                  state_ff        <= ST_SHIFT;
               end
            end
            ST_SHIFT: begin
               if (shift_hi) begin
                  for (int i = 0; i < 3; i++) begin
                     mag_ff[i] <= mag_ff[i] >> 1;
                  end
               end else if (shift_lo) begin
                  for (int i = 0; i < 3; i++) begin
                     mag_ff[i] <= mag_ff[i] << 1;
                  end
               end else begin
                  k_ff     <= '0;
                  ssum_ff  <= '0;
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ: begin
               sq_ff <= sq_src * sq_src;
               if (k_ff != 5'd0) begin
                  ssum_ff <= ssum_ff + XW'(sq_ff);
               end
               if (k_ff == 5'd3) begin
                  sx_ff    <= ssum_ff + XW'(sq_ff);
                  rt_ff    <= '0;
                  bit_ff   <= XW'(1) << (XW - 1);
                  state_ff <= ST_SQRT;
               end else begin
                  k_ff <= k_ff + 5'd1;
               end
            end
            ST_SQRT: begin
               if (bit_ff == '0) begin
                  i_ff     <= '0;
                  state_ff <= ST_DINIT;
               end else begin
                  if (sx_ff >= rt_ff + bit_ff) begin
                     sx_ff <= sx_ff - (rt_ff + bit_ff);
                     rt_ff <= (rt_ff >> 1) + bit_ff;
                  end else begin
                     rt_ff <= rt_ff >> 1;
                  end
                  bit_ff <= bit_ff >> 2;
               end
            end
            ST_DINIT: begin
               rem_ff   <= LW'(mag_ff[i_ff][NW-1:2]);
               num_ff   <= {mag_ff[i_ff][1:0], {tfu_pkg::FRAC_SHIFT{1'b0}}};
               q_ff     <= '0;
               k_ff     <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (div_t >= {1'b0, len}) begin
                  rem_ff <= LW'(div_t - {1'b0, len});
                  q_ff   <= {q_ff[QW-2:0], 1'b1};
               end else begin
                  rem_ff <= LW'(div_t);
                  q_ff   <= {q_ff[QW-2:0], 1'b0};
               end
               num_ff <= num_ff << 1;
               if (k_ff == 5'(QW - 1)) begin
                  state_ff <= ST_DFIN;
               end else begin
                  k_ff <= k_ff + 5'd1;
               end
            end
            ST_DFIN: begin
               res_ff[vec_ff][i_ff] <= sgn_ff[i_ff] ? -OW'(rnd) : OW'(rnd);
               if (i_ff == 2'd2) begin
                  state_ff <= ST_NEXT;
               end else begin
                  i_ff     <= i_ff + 2'd1;
                  state_ff <= ST_DINIT;
               end
            end
            ST_NEXT: begin
               if (!vec_ff) begin
                  vec_ff   <= 1'b1;
                  state_ff <= ST_LOAD;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  for (int i = 0; i < 3; i++) begin
                     out_ff[i]     <= flip ? -res_ff[0][i] : res_ff[0][i];
                     out_ff[3 + i] <= res_ff[1][i];
                  end
                  deg_ff       <= zero_ff[0] || zero_ff[1];
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== bench/triangle_tangent_frame_unit_tb.sv =====
// self-checking bench for the triangle tangent frame unit: vertices in, one unit
// tangent/binormal pair per triangle out, compared against a built-in predictor
// depends on tfu_pkg and triangle_tangent_frame_unit
`default_nettype none

module triangle_tangent_frame_unit_tb;

   localparam int CW        = 16;
   localparam int N_RANDOM  = 1950;
   localparam int IDLE_MAX  = 20000;

   typedef struct packed {
      logic signed [CW-1:0] px, py, pz;
      logic signed [15:0]   tu, tv;
   } vertex_type;

   typedef struct packed {
      logic signed [15:0] tx, ty, tz, bx, by, bz;
      logic               degen;
   } frame_type;

   typedef struct {
      vertex_type vtx;
      logic       known;
      frame_type  frame;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [CW-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [15:0]   req_tex_u = '0, req_tex_v = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_tangent_x, rsp_tangent_y, rsp_tangent_z;
   logic signed [15:0] rsp_binormal_x, rsp_binormal_y, rsp_binormal_z;
   logic rsp_degenerate;

   frame_type  frames_due[$];
   vertex_type held_vtx[2];
   int         held_count = 0;
   int         errors = 0;
   int         n_sent = 0;
   int         n_frames = 0;
   int         n_degen = 0;
   int         idle_cycles = 0;

   always #5 clock = ~clock;

   triangle_tangent_frame_unit #(.COORD_WIDTH(CW)) i_dut (.*);

   function automatic longint unsigned isqrt(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // returns 1 for a zero vector
   function automatic bit unit_vector(input longint v[3], output logic signed [15:0] q[3]);
      longint unsigned mag[3], m, s, len, r;
      int sr, sl;
      m = 0; s = 0; sr = 0; sl = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = (v[i] < 0) ? -v[i] : v[i];
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
         foreach (q[i]) q[i] = '0;
         return 1'b1;
      end
      while (m >= (64'd1 << 24)) begin m >>= 1; sr++; end
      while (m < (64'd1 << 23)) begin m <<= 1; sl++; end
      for (int i = 0; i < 3; i++) begin
         mag[i] = (mag[i] >> sr) << sl;
         s += mag[i] * mag[i];
      end
      len = isqrt(s);
      for (int i = 0; i < 3; i++) begin
         r = (((mag[i] << 15) / len) + 1) >> 1;
         if (r > 16384) r = 16384;
         q[i] = (v[i] < 0) ? -16'(r) : 16'(r);
      end
      return 1'b0;
   endfunction

   function automatic frame_type tangent_frame(vertex_type a, vertex_type b, vertex_type c);
      longint pa[3], pb[3], pc[3], s0[3], s1[3], tg[3], bn[3], nrm[3];
      longint du0, du1, dv0, dv1, det;
      logic signed [15:0] qt[3], qb[3];
      bit zt, zb, nz;
      frame_type f;
      pa = '{a.px, a.py, a.pz};
      pb = '{b.px, b.py, b.pz};
      pc = '{c.px, c.py, c.pz};
      for (int i = 0; i < 3; i++) begin
         s0[i] = pa[i] - pb[i];
         s1[i] = pc[i] - pa[i];
      end
      du0 = longint'(a.tu) - b.tu;
      du1 = longint'(c.tu) - a.tu;
      dv0 = longint'(a.tv) - b.tv;
      dv1 = longint'(c.tv) - a.tv;
      for (int i = 0; i < 3; i++) begin
         tg[i] = s0[i] * dv1 - s1[i] * dv0;
         bn[i] = s0[i] * du1 - s1[i] * du0;
      end
      zt = unit_vector(tg, qt);
      zb = unit_vector(bn, qb);
      nrm[0] = s0[1] * s1[2] - s0[2] * s1[1];
      nrm[1] = s0[2] * s1[0] - s0[0] * s1[2];
      nrm[2] = s0[0] * s1[1] - s0[1] * s1[0];
      nz = (nrm[0] != 0) || (nrm[1] != 0) || (nrm[2] != 0);
      det = dv0 * du1 - dv1 * du0;
      if (!zt && !zb && nz && det > 0)
         foreach (qt[i]) qt[i] = -qt[i];
      f = '{qt[0], qt[1], qt[2], qb[0], qb[1], qb[2], zt || zb};
      return f;
   endfunction

   function automatic vertex_type random_vertex(int mode);
      vertex_type  v;
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      v = raw[$bits(vertex_type)-1:0];
      if (mode == 1) begin
         // small coordinates near a shared origin
         v.px = CW'($urandom_range(0, 1023)) - CW'(512);
         v.py = CW'($urandom_range(0, 1023)) - CW'(512);
         v.pz = CW'($urandom_range(0, 1023)) - CW'(512);
         v.tu = 16'($urandom_range(0, 8191)) - 16'd4096;
         v.tv = 16'($urandom_range(0, 8191)) - 16'd4096;
      end
      return v;
   endfunction

   function automatic int idle_gap();
      return ($urandom_range(0, 9) < 6) ? 0 :
             ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) : $urandom_range(10, 60);
   endfunction

   task automatic send_vertex(vertex_type v, logic known, frame_type f);
      frame_type want;
      int        gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      {req_pos_x, req_pos_y, req_pos_z, req_tex_u, req_tex_v} <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (held_count == 2) begin
         want = tangent_frame(held_vtx[0], held_vtx[1], v);
         if (known && want !== f) begin
            $error("table frame: expected %h, predictor %h", f, want);
            errors++;
         end
         frames_due = {frames_due, want};
         held_count = 0;
      end else begin
         held_vtx[held_count] = v;
         held_count++;
      end
      n_sent++;
      @(negedge clock);
   endtask

   // receiver side stalls
   initial begin
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 199) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(20, 200)) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 99) == 0);
         end
      end
   end

   task automatic check_field(string name, logic signed [15:0] want, logic signed [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      frame_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frames_due.size() == 0) begin
            $error("unexpected result with no triangle outstanding");
            errors++;
         end else begin
            want = frames_due.pop_front();
            check_field("tangent_x", want.tx, rsp_tangent_x);
            check_field("tangent_y", want.ty, rsp_tangent_y);
            check_field("tangent_z", want.tz, rsp_tangent_z);
            check_field("binormal_x", want.bx, rsp_binormal_x);
            check_field("binormal_y", want.by, rsp_binormal_y);
            check_field("binormal_z", want.bz, rsp_binormal_z);
            check_field("degenerate", 16'(want.degen), 16'(rsp_degenerate));
            n_frames++;
            if (want.degen) n_degen++;
         end
      end
   end

   // watchdog on acceptance activity
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
         $display("watchdog expired with %0d results outstanding", frames_due.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   frame_type     zero_frame = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1};
   frame_type     no_frame = '0;
   table_row_type stim_table[$];

   function automatic vertex_type vx(int x, int y, int z, int u, int v);
      vertex_type r;
      r = '{CW'(x), CW'(y), CW'(z), 16'(u), 16'(v)};
      return r;
   endfunction

   initial begin
      frame_type  xy_frame;
      vertex_type a, b;
      bit         drained;
      drained = 1'b0;
      // right triangle in xy with uv aligned: tangent +x, binormal -y
      xy_frame = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 1'b0};
      stim_table = '{
         // all zero: degenerate
         '{vx(0, 0, 0, 0, 0), 0, no_frame},
         '{vx(0, 0, 0, 0, 0), 0, no_frame},
         '{vx(0, 0, 0, 0, 0), 1, zero_frame},
         // coincident positions, differing uv: degenerate
         '{vx(100, 100, 100, 0, 0), 0, no_frame},
         '{vx(100, 100, 100, 4096, 0), 0, no_frame},
         '{vx(100, 100, 100, 0, 4096), 1, zero_frame},
         // full-range extremes
         '{vx(-32768, 32767, -32768, 32767, -32768), 0, no_frame},
         '{vx(32767, -32768, 32767, -32768, 32767), 0, no_frame},
         '{vx(-32768, -32768, 32767, -32768, -32768), 0, no_frame},
         '{vx(32767, 32767, 32767, 32767, 32767), 0, no_frame},
         '{vx(-32768, -32768, -32768, -32768, -32768), 0, no_frame},
         '{vx(32767, -32768, 0, 0, 32767), 0, no_frame},
         // collinear vertices: no flip
         '{vx(0, 0, 0, 0, 0), 0, no_frame},
         '{vx(256, 256, 256, 4096, 0), 0, no_frame},
         '{vx(512, 512, 512, 0, 4096), 0, no_frame},
         // flat triangle, aligned uv
         '{vx(256, 0, 0, 4096, 0), 0, no_frame},
         '{vx(0, 0, 0, 0, 0), 0, no_frame},
         '{vx(256, 256, 0, 4096, 4096), 1, xy_frame},
         // mirrored uv: tangent flips
         '{vx(256, 0, 0, 0, 0), 0, no_frame},
         '{vx(0, 0, 0, 4096, 0), 0, no_frame},
         '{vx(256, 256, 0, 0, 4096), 0, no_frame}
      };
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[i])
         send_vertex(stim_table[i].vtx, stim_table[i].known, stim_table[i].frame);

      for (int n = 0; n < N_RANDOM; n++) begin
         if (!drained && n >= N_RANDOM / 2) begin
            // hold off until the pipeline has drained
            req_valid <= 1'b0;
            do @(negedge clock); while (frames_due.size() != 0);
            drained = 1'b1;
         end
         if (held_count == 0 && $urandom_range(0, 9) == 0) begin
            // degenerate triangle built from repeated vertices
            a = random_vertex($urandom_range(0, 1));
            b = random_vertex(1);
            send_vertex(a, 0, no_frame);
            send_vertex($urandom_range(0, 1) ? a : b, 0, no_frame);
            send_vertex(a, 0, no_frame);
            n += 2;
         end else begin
            send_vertex(random_vertex($urandom_range(0, 1)), 0, no_frame);
         end
      end
      req_valid <= 1'b0;

      do @(negedge clock); while (frames_due.size() != 0);
      repeat (300) @(negedge clock);
      $display("sent %0d vertices, checked %0d tangent frames (%0d degenerate)",
               n_sent, n_frames, n_degen);
      $display("directed corners, random meshes with repeated vertices, stalls on both sides");
      if (errors == 0 && frames_due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
